[hdl/gssf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssf_pkg
// Shared constants, codes and types for the gain-scheduled state-feedback
// controller.
// ----------------------------------------------------------------------------
package gssf_pkg;

  localparam int MAX_POINTS      = 16;
  localparam int FRAC_BITS       = 16;
  localparam int T_BITS          = 16;
  localparam int WORDS_PER_POINT = 10;
  localparam int WORD_W          = 32;

  localparam int GAIN_DEPTH = MAX_POINTS * WORDS_PER_POINT;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int GAIN_AW    = $clog2(GAIN_DEPTH);
  localparam int WIDX_W     = $clog2(WORDS_PER_POINT);
  localparam int T_W        = T_BITS + 1;
  localparam int ACC_W      = 2 * WORD_W - FRAC_BITS + 2;
  localparam int LP_W       = WORD_W + 1 + T_W + 1;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_BITS{1'b0}}};

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // request kinds
  localparam logic REQ_COMPUTE = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  // table word selects
  localparam logic [3:0] WSEL_BREAKPOINT = 4'd0;
  localparam logic [3:0] WSEL_LAST       = 4'(WORDS_PER_POINT);

  // word of the coordination gain within one breakpoint
  localparam logic [WIDX_W-1:0] COORD_WORD = WIDX_W'(9);

  // APB register index (taken from paddr[2])
  localparam logic REG_POINTS = 1'b0;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2,
    AXIS_COORD = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    ST_COMPUTED     = 2'd0,
    ST_UNCONFIGURED = 2'd1,
    ST_WRITE_DONE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_LO,
    S_CHK_HI,
    S_SCAN,
    S_DIV,
    S_DIVW,
    S_LRD,
    S_LSUB,
    S_LMUL,
    S_LADD,
    S_MUL_E,
    S_MUL_R,
    S_SUM,
    S_SAT,
    S_RESULT
  } fsm_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [T_W-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/gssf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssf_div
// Restoring divider for the segment fraction: quot = dividend*2^T_BITS/divisor,
// one quotient bit per cycle. Needs dividend <= divisor, so quot <= T_ONE.
// ----------------------------------------------------------------------------
module gssf_div import gssf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(T_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dvsr;
  logic [T_W-1:0]    quot;
  logic [WORD_W:0]   trial;
  logic              fits;

  // first step compares the raw dividend (integer bit), later steps shift
  assign trial = (step == '0) ? rem : {rem[WORD_W-1:0], 1'b0};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(T_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.dividend};
      dvsr <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, dvsr}) : trial;
      quot <= {quot[T_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[hdl/gain_scheduled_state_feedback.sv]
`timescale 1ns / 1ps
// Sequence: a table write or an unconfigured compute goes from its beat
//   straight to the result state. A compute runs two end-point checks, the
//   breakpoint scan (one read a cycle), the division, then S_LRD to S_LADD
//   per interpolated word (1 or 3 words), S_MUL_E to S_SAT to multiply and sum.
// Throughput: one item at a time; the next item is taken once the result is
//   in the output register. Reset clears control state and points_in_use.
// ----------------------------------------------------------------------------
// gain_scheduled_state_feedback
// Airspeed-scheduled state feedback: segment search over the breakpoint table,
// fraction by iterative division, linear interpolation of gains and trim, and
// trim + kE*error - kR*rate with saturation, or the coordination gain alone.
// ----------------------------------------------------------------------------
module gain_scheduled_state_feedback import gssf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input channel
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic                     req_type,
  input  logic [1:0]               axis,
  input  logic signed [WORD_W-1:0] airspeed,
  input  logic signed [WORD_W-1:0] command,
  input  logic signed [WORD_W-1:0] measured_value,
  input  logic signed [WORD_W-1:0] body_rate,
  input  logic [3:0]               entry_index,
  input  logic [3:0]               word_select,
  input  logic signed [WORD_W-1:0] entry_value,
  // result channel
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [WORD_W-1:0] drive_value,
  output logic [1:0]               status
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  fsm_state_t state, state_next;

  logic [4:0]       points_in_use;
  logic [CNT_W-1:0] n_pts;
  logic [IDX_W-1:0] last_idx;
  logic             configured;

  logic accept;
  logic cfg_we;

  // latched item
  axis_t                     ax;
  logic signed [WORD_W-1:0]  v_air;
  logic signed [WORD_W-1:0]  cmd;
  logic signed [WORD_W-1:0]  meas;
  logic signed [WORD_W-1:0]  rate;
  logic signed [WORD_W-1:0]  err;

  // breakpoint memory
  logic signed [WORD_W-1:0]  bp_mem [MAX_POINTS];
  logic signed [WORD_W-1:0]  bp_q;
  logic [IDX_W-1:0]          bp_raddr;
  logic                      bp_we;
  logic                      idx_ok;

  // gain memory, two read ports
  logic signed [WORD_W-1:0]  gain_mem [GAIN_DEPTH];
  logic signed [WORD_W-1:0]  ga_q;
  logic signed [WORD_W-1:0]  gb_q;
  logic [GAIN_AW-1:0]        ga_raddr;
  logic [GAIN_AW-1:0]        gb_raddr;
  logic [GAIN_AW-1:0]        gain_waddr;
  logic                      gain_we;

  // segment search
  logic [IDX_W-1:0]          k;
  logic signed [WORD_W-1:0]  prev;
  logic signed [WORD_W-1:0]  v0;
  logic signed [WORD_W-1:0]  v1;
  logic [IDX_W-1:0]          lo;
  logic [IDX_W-1:0]          hi;
  logic [T_W-1:0]            t;
  logic                      hit;
  logic                      scan_last;
  logic signed [WORD_W:0]    span_x;
  logic signed [WORD_W:0]    off_x;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // interpolation
  logic [WIDX_W-1:0]         word_base;
  logic [1:0]                word_cnt;
  logic [WIDX_W-1:0]         widx;
  logic signed [WORD_W-1:0]  a_hold;
  logic signed [WORD_W:0]    ab_diff;
  logic signed [LP_W-1:0]    lerp_prod;
  logic signed [LP_W-1:0]    lerp_sum;
  logic signed [WORD_W-1:0]  lerp_val;
  logic signed [WORD_W-1:0]  ke;
  logic signed [WORD_W-1:0]  kr;
  logic signed [WORD_W-1:0]  trim;

  // shared multiplier and accumulator
  logic signed [WORD_W-1:0]   mul_a;
  logic signed [WORD_W-1:0]   mul_b;
  logic signed [2*WORD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    mul_term;

  logic signed [WORD_W-1:0]  res_value;
  status_t                   res_status;
  logic                      load_out;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = ACC_W'(WORD_MAX);
    lo_lim = ACC_W'(WORD_MIN);
    if (x > hi_lim) begin
      return WORD_MAX;
    end else if (x < lo_lim) begin
      return WORD_MIN;
    end else begin
      return WORD_W'(x);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. One register; paddr[2] picks it, low bits are the
  // byte offset. A point count above the table size counts as a full table.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_POINTS);
  assign prdata = (paddr[2] == REG_POINTS) ? 32'(points_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_we) begin
      points_in_use <= pwdata[4:0];
    end
  end

  assign n_pts      = (32'(points_in_use) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(points_in_use);
  assign last_idx   = IDX_W'(n_pts - 1'b1);
  assign configured = (32'(n_pts) >= 2);

  // --------------------------------------------------------------------------
  // Table writes happen on the accepting edge of a write beat.
  // --------------------------------------------------------------------------
  assign accept  = item_valid && item_ready;
  assign idx_ok  = (32'(entry_index) < MAX_POINTS);
  assign bp_we   = accept && (req_type == REQ_WRITE) && idx_ok &&
                   (word_select == WSEL_BREAKPOINT);
  assign gain_we = accept && (req_type == REQ_WRITE) && idx_ok &&
                   (word_select != WSEL_BREAKPOINT) && (word_select <= WSEL_LAST);
  assign gain_waddr = GAIN_AW'(32'(entry_index) * WORDS_PER_POINT + 32'(word_select) - 1);

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[IDX_W'(entry_index)] <= entry_value;
    end
    bp_q <= bp_mem[bp_raddr];
  end

  // gain words of the lower and upper breakpoint come out side by side
  assign widx     = word_base + WIDX_W'(word_cnt);
  assign ga_raddr = GAIN_AW'(32'(lo) * WORDS_PER_POINT + 32'(widx));
  assign gb_raddr = GAIN_AW'(32'(hi) * WORDS_PER_POINT + 32'(widx));

  always_ff @(posedge clk) begin
    if (gain_we) begin
      gain_mem[gain_waddr] <= entry_value;
    end
    ga_q <= gain_mem[ga_raddr];
  end

  always_ff @(posedge clk) begin
    gb_q <= gain_mem[gb_raddr];
  end

  // --------------------------------------------------------------------------
  // Segment search helpers. bp_q holds bp[k] in S_SCAN, prev holds bp[k-1].
  // --------------------------------------------------------------------------
  assign hit       = (k != '0) && (prev <= v_air) && (v_air <= bp_q);
  assign scan_last = (k == last_idx);

  // both differences are non-negative once a segment is found
  assign span_x = (WORD_W+1)'(v1) - (WORD_W+1)'(v0);
  assign off_x  = (WORD_W+1)'(v_air) - (WORD_W+1)'(v0);

  gssf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // lerp: a + floor((b - a) * t / 2^T_BITS)
  assign lerp_sum = LP_W'(a_hold) + (lerp_prod >>> T_BITS);
  assign lerp_val = WORD_W'(lerp_sum);

  assign mul_term = ACC_W'(mul_p >>> FRAC_BITS);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_WRITE || !configured) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_CHK_LO;
          end
        end
      end
      S_CHK_LO: begin
        state_next = (v_air <= bp_q) ? S_LRD : S_CHK_HI;
      end
      S_CHK_HI: begin
        state_next = (v_air >= bp_q) ? S_LRD : S_SCAN;
      end
      S_SCAN: begin
        priority if (hit) begin
          state_next = S_DIV;
        end else if (scan_last) begin
          state_next = S_LRD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_DIV:   state_next = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_next = S_LRD;
        end
      end
      S_LRD:   state_next = S_LSUB;
      S_LSUB:  state_next = S_LMUL;
      S_LMUL:  state_next = S_LADD;
      S_LADD: begin
        priority if (ax == AXIS_COORD) begin
          state_next = S_RESULT;
        end else if (word_cnt == 2'd2) begin
          state_next = S_MUL_E;
        end else begin
          state_next = S_LRD;
        end
      end
      S_MUL_E: state_next = S_MUL_R;
      S_MUL_R: state_next = S_SUM;
      S_SUM:   state_next = S_SAT;
      S_SAT:   state_next = S_RESULT;
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (read addresses, divider start, multiplier operands)
  // --------------------------------------------------------------------------
  always_comb begin
    item_ready       = 1'b0;
    load_out         = 1'b0;
    bp_raddr         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = WORD_W'(off_x);
    div_req.divisor  = (span_x == '0) ? WORD_W'(1) : WORD_W'(span_x);
    mul_a            = ke;
    mul_b            = err;
    unique case (state)
      S_IDLE:   item_ready = 1'b1;
      S_CHK_LO: bp_raddr   = last_idx;
      S_CHK_HI: bp_raddr   = '0;
      S_SCAN:   bp_raddr   = k + 1'b1;
      S_DIV:    div_req.start = 1'b1;
      S_MUL_E: begin
        mul_a = ke;
        mul_b = err;
      end
      S_MUL_R: begin
        mul_a = kr;
        mul_b = rate;
      end
      S_RESULT: load_out = !result_valid || result_ready;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ax        <= axis_t'(axis);
          v_air     <= airspeed;
          cmd       <= command;
          meas      <= measured_value;
          rate      <= body_rate;
          word_cnt  <= '0;
          word_base <= (axis_t'(axis) == AXIS_COORD) ? COORD_WORD
                                                      : WIDX_W'(3 * 32'(axis));
          res_value <= '0;
          if (req_type == REQ_WRITE) begin
            res_status <= ST_WRITE_DONE;
          end else begin
            res_status <= configured ? ST_COMPUTED : ST_UNCONFIGURED;
          end
        end
      end
      S_CHK_LO: begin
        // yaw error uses the body rate, roll and pitch the measured angle
        err <= sat_word(ACC_W'(cmd) - ACC_W'((ax == AXIS_YAW) ? rate : meas));
        lo  <= '0;
        hi  <= '0;
        t   <= '0;
      end
      S_CHK_HI: begin
        lo <= last_idx;
        hi <= last_idx;
        t  <= '0;
        k  <= '0;
      end
      S_SCAN: begin
        priority if (hit) begin
          lo <= k - 1'b1;
          hi <= k;
          v0 <= prev;
          v1 <= bp_q;
        end else if (scan_last) begin
          // no segment matched: hold the last point
          lo <= last_idx;
          hi <= last_idx;
          t  <= '0;
        end else begin
          prev <= bp_q;
          k    <= k + 1'b1;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          t <= div_rsp.quot;
        end
      end
      S_LSUB: begin
        a_hold  <= ga_q;
        ab_diff <= (WORD_W+1)'(gb_q) - (WORD_W+1)'(ga_q);
      end
      S_LMUL: begin
        lerp_prod <= ab_diff * $signed({1'b0, t});
      end
      S_LADD: begin
        if (ax == AXIS_COORD) begin
          res_value <= lerp_val;
        end else begin
          unique case (word_cnt)
            2'd0:    ke   <= lerp_val;
            2'd1:    kr   <= lerp_val;
            default: trim <= lerp_val;
          endcase
          word_cnt <= word_cnt + 1'b1;
        end
      end
      S_MUL_R: acc <= ACC_W'(trim) + mul_term;   // mul_p = kE * err
      S_SUM:   acc <= acc - mul_term;            // mul_p = kR * rate
      S_SAT:   res_value <= sat_word(acc);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: parts the sequencer from the downstream stall
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_value <= res_value;
      status      <= res_status;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_write_reports: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_WRITE) |=>
      (state == S_RESULT && res_status == ST_WRITE_DONE))
    else $error("table write beat did not go straight to a write-done result");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (div_rsp.quot <= T_ONE))
    else $error("segment fraction above one");

  a_segment_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_LSUB) |-> (lo <= hi && hi <= last_idx))
    else $error("interpolation segment out of order or beyond the points in use");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_RESULT))
    else $error("result presented outside the result state");

endmodule

[dv/gain_scheduled_state_feedback_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_scheduled_state_feedback_tb
// Self-checking bench for the gain-scheduled controller. Directed table rows
// cover the unconfigured controller, out-of-range word selects, clamping at
// both ends of the schedule, exact breakpoint hits, a duplicated breakpoint,
// a one-LSB segment, a descending segment and saturation. Random phases
// follow, each at a set point count. Every result beat is checked against the
// row's typed result or a bit-accurate predictor of the control law.
// ----------------------------------------------------------------------------
module gain_scheduled_state_feedback_tb import gssf_pkg::*; ();

  // --------------------------------------------------------------------------
  // Bench constants
  // --------------------------------------------------------------------------
  localparam int RESET_CYCLES   = 4;
  localparam int IDLE_PCT       = 26;    // per-cycle idle chance on each side
  localparam int WRITE_PCT      = 22;    // share of table writes in random phases
  localparam int SETTLE_CYCLES  = 64;    // settle gap after each drain
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
  localparam int UNIT           = 1 << FRAC_BITS;   // 1.0 in Q16.16
  localparam int SMALL_SPAN     = 1 << 20;          // +/-16.0
  localparam longint BP_REACH   = 1 << 24;          // spread of end-point writes
  localparam longint T_FULL     = longint'(1) <<< T_BITS;

  localparam logic [3:0] WSEL_UNUSED_LO = WSEL_LAST + 4'd1;
  localparam logic [3:0] WSEL_UNUSED_HI = 4'hF;

  // point counts of the random phases: extremes, the clamped 5-bit maximum,
  // and both unconfigured values; the 31-point phase runs with no idling
  localparam int PHASE_N      = 8;
  localparam int STEADY_PHASE = 2;
  localparam int PHASE_POINTS [PHASE_N] = '{16, 2, 31, 1, 9, 0, 3, 16};
  localparam int PHASE_ITEMS  [PHASE_N] = '{120, 50, 60, 25, 70, 20, 40, 70};

  // --------------------------------------------------------------------------
  // Beat types
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic              req;
    axis_t             axis;
    logic signed [31:0] airspeed;
    logic signed [31:0] command;
    logic signed [31:0] measured_value;
    logic signed [31:0] body_rate;
    logic [3:0]        entry_index;
    logic [3:0]        word_select;
    logic signed [31:0] entry_value;
  } ctl_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    status_t            status;
  } drive_beat_t;

  typedef struct packed {
    ctl_item_t   item;
    logic        typed;   // expected result typed into the row
    drive_beat_t want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               item_valid = 1'b0;
  logic               item_ready;
  logic               req_type = REQ_COMPUTE;
  logic [1:0]         axis = '0;
  logic signed [31:0] airspeed = '0;
  logic signed [31:0] command = '0;
  logic signed [31:0] measured_value = '0;
  logic signed [31:0] body_rate = '0;
  logic [3:0]         entry_index = '0;
  logic [3:0]         word_select = '0;
  logic signed [31:0] entry_value = '0;

  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] drive_value;
  logic [1:0]         status;

  gain_scheduled_state_feedback DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .req_type       (req_type),
    .axis           (axis),
    .airspeed       (airspeed),
    .command        (command),
    .measured_value (measured_value),
    .body_rate      (body_rate),
    .entry_index    (entry_index),
    .word_select    (word_select),
    .entry_value    (entry_value),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .drive_value    (drive_value),
    .status         (status)
  );

  // --------------------------------------------------------------------------
  // Shadow schedule and expected results
  // --------------------------------------------------------------------------
  logic [4:0]         sched_points = '0;
  logic signed [31:0] sched_bp   [MAX_POINTS];
  logic signed [31:0] sched_gain [GAIN_DEPTH];

  drive_beat_t pending_drive_q [$];

  bit steady_run = 1'b0;   // no idling on either side while set
  int fail_count = 0;
  int results_seen = 0;
  int computes_sent = 0;
  int writes_sent = 0;
  int unconf_beats = 0;
  int sat_beats = 0;

  function automatic longint sat32(longint x);
    if (x > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (x < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return x;
  endfunction

  function automatic longint lerp_gain(int lo, int hi, int w, longint t);
    longint a, b;
    a = sched_gain[lo * WORDS_PER_POINT + w];
    b = sched_gain[hi * WORDS_PER_POINT + w];
    // arithmetic shift floors, so the result stays between a and b
    return a + (((b - a) * t) >>> T_BITS);
  endfunction

  // Applies one input beat to the shadow schedule and returns its result.
  function automatic drive_beat_t controller_step(ctl_item_t it);
    drive_beat_t beat;
    int n, lo, hi, base;
    longint v, v0, v1, t, span, ke, kr, trim, cmd, sense, err, rate, res;
    bit found;
    beat.drive = '0;
    if (it.req == REQ_WRITE) begin
      // an index past the table, or a word select past the coordination
      // gain, stores nothing but still reports the write
      if (int'(it.entry_index) < MAX_POINTS) begin
        if (it.word_select == WSEL_BREAKPOINT) begin
          sched_bp[it.entry_index] = it.entry_value;
        end else if (it.word_select <= WSEL_LAST) begin
          sched_gain[int'(it.entry_index) * WORDS_PER_POINT
                     + int'(it.word_select) - 1] = it.entry_value;
        end
      end
      beat.status = ST_WRITE_DONE;
      return beat;
    end
    n = (int'(sched_points) > MAX_POINTS) ? MAX_POINTS : int'(sched_points);
    if (n < 2) begin
      beat.status = ST_UNCONFIGURED;
      return beat;
    end
    // segment search: clamp at either end, else first bracketing pair
    v = $signed(it.airspeed);
    t = 0;
    found = 1'b0;
    if (v <= sched_bp[0]) begin
      lo = 0;
      hi = 0;
    end else if (v >= sched_bp[n-1]) begin
      lo = n - 1;
      hi = n - 1;
    end else begin
      lo = n - 1;
      hi = n - 1;
      for (int i = 0; i + 1 < n && !found; i++) begin
        v0 = sched_bp[i];
        v1 = sched_bp[i+1];
        if (v >= v0 && v <= v1) begin
          span = v1 - v0;
          if (span < 1) span = 1;
          t = ((v - v0) <<< T_BITS) / span;
          if (t > T_FULL) t = T_FULL;
          lo = i;
          hi = i + 1;
          found = 1'b1;
        end
      end
    end
    if (it.axis == AXIS_COORD) begin
      res = lerp_gain(lo, hi, int'(COORD_WORD), t);
    end else begin
      base  = int'(it.axis) * 3;
      ke    = lerp_gain(lo, hi, base, t);
      kr    = lerp_gain(lo, hi, base + 1, t);
      trim  = lerp_gain(lo, hi, base + 2, t);
      cmd   = $signed(it.command);
      rate  = $signed(it.body_rate);
      // yaw error is rate command minus measured rate
      sense = (it.axis == AXIS_YAW) ? rate : longint'($signed(it.measured_value));
      err   = sat32(cmd - sense);
      res   = sat32(trim + ((ke * err) >>> FRAC_BITS) - ((kr * rate) >>> FRAC_BITS));
    end
    beat.drive  = 32'(res);
    beat.status = ST_COMPUTED;
    return beat;
  endfunction

  // --------------------------------------------------------------------------
  // Random value helpers
  // --------------------------------------------------------------------------
  function automatic longint pick_between(longint lo, longint hi);
    longint unsigned span, raw;
    span = longint'(hi - lo + 1);
    raw  = {$urandom, $urandom};
    return lo + longint'(raw % span);
  endfunction

  // mostly small Q16.16 values; wide_pct percent from the full range
  function automatic logic signed [31:0] rand_word(int wide_pct);
    if ($urandom_range(0, 99) < wide_pct) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        default: return $urandom;
      endcase
    end
    return $signed(32'($urandom_range(0, 2 * SMALL_SPAN))) - SMALL_SPAN;
  endfunction

  function automatic ctl_item_t scrambled_item();
    ctl_item_t it;
    it.req            = REQ_COMPUTE;
    it.axis           = axis_t'($urandom_range(0, 3));
    it.airspeed       = $urandom;
    it.command        = rand_word(20);
    it.measured_value = rand_word(20);
    it.body_rate      = rand_word(20);
    it.entry_index    = 4'($urandom_range(0, MAX_POINTS - 1));
    it.word_select    = ($urandom_range(0, 99) < 85) ?
                        4'($urandom_range(0, WORDS_PER_POINT)) : 4'($urandom);
    it.entry_value    = rand_word(25);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic dir_row_t row_compute(axis_t ax, int v, int c, int m, int r,
                                           bit unconf);
    dir_row_t row;
    row = '0;
    row.item.req            = REQ_COMPUTE;
    row.item.axis           = ax;
    row.item.airspeed       = v;
    row.item.command        = c;
    row.item.measured_value = m;
    row.item.body_rate      = r;
    row.typed               = unconf;
    row.want.status         = ST_UNCONFIGURED;
    return row;
  endfunction

  function automatic dir_row_t row_write(int idx, logic [3:0] ws, int val);
    dir_row_t row;
    row = '0;
    row.item.req         = REQ_WRITE;
    row.item.entry_index = 4'(idx);
    row.item.word_select = ws;
    row.item.entry_value = val;
    row.typed            = 1'b1;
    row.want.status      = ST_WRITE_DONE;
    return row;
  endfunction

  // First DIR_UNCONF_N rows run straight after reset with no points in use;
  // the rest run against the breakpoint ladder loaded below:
  // -60 -40 -20 0 20 40 40 40+lsb 100 120 ... 240
  localparam int DIR_UNCONF_N = 7;
  localparam int DIR_N        = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // unconfigured: zero drive on every axis whatever the inputs
    row_compute(AXIS_ROLL,  WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1),
    row_compute(AXIS_PITCH, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1'b1),
    row_compute(AXIS_YAW,   0, -1, 0, -1, 1'b1),
    row_compute(AXIS_COORD, -1, 0, -1, 0, 1'b1),
    // word selects past the coordination gain store nothing, then the gain itself
    row_write(MAX_POINTS - 1, WSEL_UNUSED_LO, WORD_MAX),
    row_write(0, WSEL_UNUSED_HI, WORD_MIN),
    row_write(MAX_POINTS - 1, WSEL_LAST, -1),
    // clamping below and above the schedule
    row_compute(AXIS_ROLL,  WORD_MIN, 5 * UNIT, -3 * UNIT, 2 * UNIT, 1'b0),
    row_compute(AXIS_PITCH, WORD_MAX, -7 * UNIT, UNIT, -UNIT, 1'b0),
    // exact end points, an inner point (t = 1 on the lower segment), a mid-segment value
    row_compute(AXIS_YAW,   -60 * UNIT, 3 * UNIT, 0, UNIT / 2, 1'b0),
    row_compute(AXIS_COORD, 240 * UNIT, 0, 0, 0, 1'b0),
    row_compute(AXIS_ROLL,  0, UNIT, -UNIT, 0, 1'b0),
    row_compute(AXIS_PITCH, 10 * UNIT + 'h1234, -UNIT, 2 * UNIT, 3 * UNIT, 1'b0),
    // duplicated breakpoint, then the one-LSB segment
    row_compute(AXIS_YAW,   40 * UNIT, 4 * UNIT, 0, -2 * UNIT, 1'b0),
    row_compute(AXIS_COORD, 40 * UNIT + 1, 0, 0, 0, 1'b0),
    row_compute(AXIS_ROLL,  70 * UNIT, -UNIT, UNIT, UNIT, 1'b0),
    // error and product saturation
    row_compute(AXIS_ROLL,  30 * UNIT, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0),
    row_compute(AXIS_PITCH, 150 * UNIT, WORD_MIN, WORD_MAX, WORD_MAX, 1'b0),
    row_compute(AXIS_YAW,   -50 * UNIT, WORD_MIN, 0, WORD_MAX, 1'b0),
    row_compute(AXIS_YAW,   239 * UNIT, WORD_MAX, 0, WORD_MIN, 1'b0),
    row_compute(AXIS_COORD, -1, 0, 0, 0, 1'b0),
    // descending segment: point 1 below point 0, then restored
    row_write(1, WSEL_BREAKPOINT, -100 * UNIT),
    row_compute(AXIS_ROLL,  -30 * UNIT, 2 * UNIT, UNIT, -UNIT, 1'b0),
    row_write(1, WSEL_BREAKPOINT, -40 * UNIT)
  };

  // --------------------------------------------------------------------------
  // Drivers (inputs change on the falling edge)
  // --------------------------------------------------------------------------
  // Entered and left on a falling edge. Valid is only lowered by an idle
  // cycle here or by drain_results, never in the same step it is raised.
  task automatic push_item(input ctl_item_t it, input bit typed,
                           input drive_beat_t typed_want);
    drive_beat_t want;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid     <= 1'b1;
    req_type       <= it.req;
    axis           <= it.axis;
    airspeed       <= it.airspeed;
    command        <= it.command;
    measured_value <= it.measured_value;
    body_rate      <= it.body_rate;
    entry_index    <= it.entry_index;
    word_select    <= it.word_select;
    entry_value    <= it.entry_value;
    do @(posedge clk); while (!item_ready);
    want = controller_step(it);
    if (typed) want = typed_want;
    pending_drive_q = {pending_drive_q, want};
    if (it.req == REQ_WRITE) begin
      writes_sent++;
    end else begin
      computes_sent++;
      if (want.status == ST_UNCONFIGURED) unconf_beats++;
      if (want.status == ST_COMPUTED && (want.drive == WORD_MAX || want.drive == WORD_MIN))
        sat_beats++;
    end
    @(negedge clk);
  endtask

  // APB write of points_in_use: setup cycle, then access cycle
  task automatic write_points(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POINTS, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sched_points = 5'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender holds off until every expected beat is back, then a settle gap
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result back-pressure
  always @(negedge clk) begin
    result_ready <= !rst && (steady_run || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Result checker (sampled on the rising edge)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    drive_beat_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_drive_q.size() == 0) begin
        $display("%0t: unexpected result beat: drive_value %0d status %0d",
                 $time, drive_value, status);
        fail_count++;
      end else begin
        want = pending_drive_q.pop_front();
        if (drive_value !== want.drive) begin
          $display("%0t: beat %0d drive_value mismatch: expected %0d, actual %0d",
                   $time, results_seen, $signed(want.drive), drive_value);
          fail_count++;
        end
        if (status !== want.status) begin
          $display("%0t: beat %0d status mismatch: expected %0d, actual %0d",
                   $time, results_seen, want.status, status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no beat on either channel
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_drive_q.size());
      $display("FAIL gain_scheduled_state_feedback");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    ctl_item_t   it;
    drive_beat_t none;
    int          n, r, i;
    longint      lo_v, hi_v;
    none = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    write_points(0);

    // directed rows with nothing configured
    for (int k = 0; k < DIR_UNCONF_N; k++)
      push_item(DIR_ROWS[k].item, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    drain_results();

    // load every word of the table: breakpoint ladder, random gains
    for (int e = 0; e < MAX_POINTS; e++) begin
      for (int w = 0; w <= WORDS_PER_POINT; w++) begin
        it             = scrambled_item();
        it.req         = REQ_WRITE;
        it.entry_index = 4'(e);
        it.word_select = 4'(w);
        if (w == 0) begin
          it.entry_value = (e == 6) ? 40 * UNIT :
                           (e == 7) ? 40 * UNIT + 1 : (e * 20 - 60) * UNIT;
        end else begin
          it.entry_value = rand_word(15);
        end
        push_item(it, 1'b0, none);
      end
    end
    drain_results();

    write_points(MAX_POINTS);
    for (int k = DIR_UNCONF_N; k < DIR_N; k++)
      push_item(DIR_ROWS[k].item, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    drain_results();

    // random phases, one point count each
    for (int p = 0; p < PHASE_N; p++) begin
      write_points(PHASE_POINTS[p]);
      steady_run = (p == STEADY_PHASE);
      n = (PHASE_POINTS[p] > MAX_POINTS) ? MAX_POINTS : PHASE_POINTS[p];
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        it = scrambled_item();
        if ($urandom_range(0, 99) < WRITE_PCT) begin
          it.req = REQ_WRITE;
          // breakpoint writes mostly stay between their neighbours
          if (it.word_select == WSEL_BREAKPOINT && $urandom_range(0, 99) < 80) begin
            i    = int'(it.entry_index);
            lo_v = (i == 0) ? longint'(sched_bp[1]) - BP_REACH
                            : longint'(sched_bp[i-1]);
            hi_v = (i == MAX_POINTS - 1) ? longint'(sched_bp[MAX_POINTS-2]) + BP_REACH
                                         : longint'(sched_bp[i+1]);
            if (lo_v <= hi_v) it.entry_value = 32'(sat32(pick_between(lo_v, hi_v)));
          end
        end else if (n >= 2) begin
          // airspeed: exact point, inside a segment, just past an end,
          // or anywhere (left as drawn)
          r = $urandom_range(0, 99);
          i = $urandom_range(0, n - 2);
          if (r < 20) begin
            it.airspeed = sched_bp[$urandom_range(0, n - 1)];
          end else if (r < 70) begin
            lo_v = sched_bp[i];
            hi_v = sched_bp[i+1];
            if (lo_v > hi_v) {lo_v, hi_v} = {hi_v, lo_v};
            it.airspeed = 32'(pick_between(lo_v, hi_v));
          end else if (r < 75) begin
            it.airspeed = 32'(sat32(longint'(sched_bp[0])
                                    - longint'($urandom_range(1, SMALL_SPAN))));
          end else if (r < 80) begin
            it.airspeed = 32'(sat32(longint'(sched_bp[n-1])
                                    + longint'($urandom_range(1, SMALL_SPAN))));
          end
        end
        push_item(it, 1'b0, none);
      end
      drain_results();
      steady_run = 1'b0;
    end

    $display("Covered %0d compute beats (%0d unconfigured, %0d saturated), %0d table writes",
             computes_sent, unconf_beats, sat_beats, writes_sent);
    $display("over point counts 0..31 with random stalls; %0d results checked, %0d errors",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS gain_scheduled_state_feedback");
    end else begin
      $display("FAIL gain_scheduled_state_feedback");
    end
    $finish;
  end

endmodule
